// ===== rtl/masked_temporal_frame_smoother_assert.svh =====
// Assertion macros for the frame smoother RTL.
// Self-contained; included by mtfs_datapath, which checks its own pipeline state.
`ifndef MASKED_TEMPORAL_FRAME_SMOOTHER_ASSERT_SVH
`define MASKED_TEMPORAL_FRAME_SMOOTHER_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define MTFS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define MTFS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define MTFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtfs_pkg.sv =====
// Shared types and constants for the masked temporal frame smoother.
// No dependencies; imported by every module of the block.
`default_nettype none

package mtfs_pkg;

    // Field widths
    localparam int PIX_W   = 16;
    localparam int GAIN_W  = 17;
    localparam int FRAME_W = 19;

    // Defaults
    localparam int MAX_PIXELS_DEF = 262144;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd6554;
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'h10000;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 19'd262144;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MASK_ENABLE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

    // Output skid FIFO
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Per-pixel update choice
    typedef enum logic [1:0] {
        MODE_SMOOTH = 2'd0,
        MODE_HOLD   = 2'd1,
        MODE_LOAD   = 2'd2
    } upd_mode_t;

    // Settings seen by the datapath (already saturated)
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              mask_enable;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] pixel_out;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/mtfs_cfg.sv =====
// APB register file: gain, mask enable, frame size.
// Uses mtfs_pkg; keeps saturated copies for the datapath.
`default_nettype none

module mtfs_cfg
    import mtfs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,
    output cfg_t                        cfg,
    output logic [$clog2(MAX_PIXELS)-1:0] last_idx
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;

    // Index of the last pixel for a frame size; zero acts as one, oversize clamps
    function automatic logic [AW-1:0] last_of(input logic [FRAME_W-1:0] fp);
        logic [SW-1:0] fp_ext;
        fp_ext = SW'(fp);
        if (fp_ext == '0)
            return '0;
        else if (fp_ext > SW'(MAX_PIXELS))
            return AW'(MAX_PIXELS - 1);
        else
            return AW'(fp_ext - SW'(1));
    endfunction

    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_eff_reg;
    logic               mask_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [AW-1:0]      last_idx_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [GAIN_W-1:0]    wr_gain;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_gain = pwdata[GAIN_W-1:0];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_RESET;
            gain_eff_reg <= GAIN_RESET;
            mask_reg     <= 1'b0;
            frame_reg    <= FRAME_RESET;
            last_idx_reg <= last_of(FRAME_RESET);
        end else if (wr_en) begin
            if (reg_idx == REG_GAIN) begin
                gain_reg     <= wr_gain;
                gain_eff_reg <= (wr_gain > GAIN_ONE) ? GAIN_ONE : wr_gain;
            end
            if (reg_idx == REG_MASK_ENABLE) begin
                mask_reg <= pwdata[0];
            end
            if (reg_idx == REG_FRAME_PIXELS) begin
                frame_reg    <= pwdata[FRAME_W-1:0];
                last_idx_reg <= last_of(pwdata[FRAME_W-1:0]);
            end
        end
    end

    // Readback
    always_comb begin
        unique case (reg_idx)
            REG_GAIN:         prdata = APB_DATA_W'(gain_reg);
            REG_MASK_ENABLE:  prdata = APB_DATA_W'(mask_reg);
            REG_FRAME_PIXELS: prdata = APB_DATA_W'(frame_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.gain        = gain_eff_reg;
    assign cfg.mask_enable = mask_reg;
    assign last_idx        = last_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/mtfs_datapath.sv =====
// Pixel counter, frame store and the two-stage smoothing pipeline.
// Uses mtfs_pkg and the assertion macros header.
`default_nettype none
`include "masked_temporal_frame_smoother_assert.svh"

module mtfs_datapath
    import mtfs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [PIX_W-1:0]        pixel_in,
    input  wire logic                    motion_flag,
    input  wire logic                    reload,
    input  wire cfg_t                    cfg,
    input  wire logic [$clog2(MAX_PIXELS)-1:0] last_idx,
    input  wire logic [FIFO_CNT_W-1:0]   fifo_count,
    output logic                         push,
    output out_beat_t                    push_beat
);

    localparam int AW = $clog2(MAX_PIXELS);

    // Frame store: one read at accept, one write-back from stage 2
    logic [PIX_W-1:0] store_mem [MAX_PIXELS];
    logic [PIX_W-1:0] prev_reg;

    logic [AW-1:0] idx_reg, idx_next;

    // Stage 1
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_motion_reg;
    logic             s1_reload_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_last_reg;

    // Stage 2
    logic             s2_valid_reg;
    logic [PIX_W-1:0] s2_pix_reg;
    logic [PIX_W-1:0] s2_prev_reg;
    logic [PIX_W-1:0] s2_off_reg;
    logic             s2_up_reg;
    upd_mode_t        s2_mode_reg;
    logic [AW-1:0]    s2_addr_reg;
    logic             s2_last_reg;

    logic                  accept;
    logic                  hazard;
    logic                  room;
    logic                  is_last;
    logic [FIFO_CNT_W-1:0] in_flight;

    logic                    s1_up;
    logic [PIX_W-1:0]        s1_mag;
    logic [PIX_W+GAIN_W-1:0] s1_prod;
    upd_mode_t               s1_mode;
    logic [PIX_W-1:0]        s2_res;

    // Flow control: credit for the output FIFO, and no read of an entry still in flight
    assign in_flight = fifo_count + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg);
    assign room      = in_flight < FIFO_CNT_W'(FIFO_DEPTH);
    assign hazard    = (s1_valid_reg && (s1_addr_reg == idx_reg))
                    || (s2_valid_reg && (s2_addr_reg == idx_reg));
    assign in_ready  = room && !hazard;
    assign accept    = in_valid && in_ready;

    // Pixel counter
    assign is_last  = idx_reg >= last_idx;
    assign idx_next = is_last ? '0 : AW'(idx_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (accept) begin
            idx_reg <= idx_next;
        end
    end

    // Store read at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg <= store_mem[idx_reg];
        end
    end

    // Store write-back
    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            store_mem[s2_addr_reg] <= s2_res;
        end
    end

    // Stage 1 capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg    <= pixel_in;
            s1_motion_reg <= motion_flag;
            s1_reload_reg <= reload;
            s1_addr_reg   <= idx_reg;
            s1_last_reg   <= is_last;
        end
    end

    // Stage 1: magnitude of the step and gain product
    assign s1_up   = s1_pix_reg >= prev_reg;
    assign s1_mag  = s1_up ? (s1_pix_reg - prev_reg) : (prev_reg - s1_pix_reg);
    assign s1_prod = (PIX_W + GAIN_W)'(s1_mag) * (PIX_W + GAIN_W)'(cfg.gain);

    // Reload wins over the mask
    always_comb begin
        priority if (s1_reload_reg)
            s1_mode = MODE_LOAD;
        else if (cfg.mask_enable && !s1_motion_reg)
            s1_mode = MODE_HOLD;
        else
            s1_mode = MODE_SMOOTH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Offset never exceeds the magnitude, so bits above 16+16 are zero
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_pix_reg  <= s1_pix_reg;
            s2_prev_reg <= prev_reg;
            s2_off_reg  <= s1_prod[2*PIX_W-1:PIX_W];
            s2_up_reg   <= s1_up;
            s2_mode_reg <= s1_mode;
            s2_addr_reg <= s1_addr_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 2: apply the offset toward the new pixel
    always_comb begin
        unique case (s2_mode_reg)
            MODE_LOAD: s2_res = s2_pix_reg;
            MODE_HOLD: s2_res = s2_prev_reg;
            MODE_SMOOTH: s2_res = s2_up_reg ? (s2_prev_reg + s2_off_reg)
                                            : (s2_prev_reg - s2_off_reg);
            default:   s2_res = s2_prev_reg;
        endcase
    end

    assign push                = s2_valid_reg;
    assign push_beat.pixel_out = s2_res;
    assign push_beat.frame_end = s2_last_reg;

    // Checks
    `MTFS_ASSERT_IMPLY(a_no_addr_alias, aclk, aresetn, s1_valid_reg && s2_valid_reg,
        s1_addr_reg != s2_addr_reg, "two in-flight pixels share a store entry")
    `MTFS_ASSERT_ALWAYS(a_credit, aclk, aresetn, in_flight <= FIFO_CNT_W'(FIFO_DEPTH),
        "more beats in flight than the output FIFO holds")
    `MTFS_ASSERT_NEXT(a_wrap, aclk, aresetn, accept && is_last, idx_reg == '0,
        "pixel counter did not wrap after the last pixel")
    `MTFS_ASSERT_IMPLY(a_mode_load, aclk, aresetn, s1_valid_reg && s1_reload_reg,
        s1_mode == MODE_LOAD, "reload did not take precedence")

endmodule

`default_nettype wire

// ===== rtl/mtfs_out_fifo.sv =====
// Small result FIFO that decouples the pipeline from the output handshake.
// Uses mtfs_pkg; the pipeline only pushes when a credit is free.
`default_nettype none

module mtfs_out_fifo
    import mtfs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire out_beat_t             push_beat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_beat_t                  out_beat,
    output logic [FIFO_CNT_W-1:0]      count
);

    out_beat_t slot_reg [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : FIFO_PTR_W'(p + 1'b1);
    endfunction

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_beat  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= FIFO_CNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= FIFO_CNT_W'(count_reg - 1'b1);
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/masked_temporal_frame_smoother.sv =====
// Channel   Dir  Beat contents
// s_        in   tdata[15:0] pixel_in; tuser[0] motion_flag, tuser[1] reload
// m_        out  tdata[15:0] pixel_out; tlast frame_end
// APB       in   0x0 gain, 0x4 mask_enable, 0x8 frame_pixels
//
// One pixel per cycle while s_tready is high; a result passes the stage 1 and stage 2
// registers and is written into the result FIFO before m_tvalid rises for it.
// The frame store is read at accept and written back from stage 2, so in frames
// of one or two pixels a pixel waits while the entry it reads is in stage 1 or 2.
// The credit for the four-entry FIFO also counts the beats in the two stages, so
// s_tready drops once four beats are held or in flight while m_tready is low.
// Reset clears the settings, counter, pipeline and FIFO, not the store, which holds no
// data until the first frame is loaded with reload set on every pixel.
//
// Top level; uses mtfs_pkg, mtfs_cfg, mtfs_datapath and mtfs_out_fifo.
`default_nettype none

module masked_temporal_frame_smoother
    import mtfs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input pixels
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] pixel_in
    input  wire logic [1:0]            s_tuser,   // [0] motion_flag, [1] reload
    // Smoothed pixels
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [15:0] pixel_out
    output logic                       m_tlast,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int AW = $clog2(MAX_PIXELS);

    cfg_t                  cfg;
    logic [AW-1:0]         last_idx;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  push;
    out_beat_t             push_beat;
    out_beat_t             out_beat;

    mtfs_cfg #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .last_idx (last_idx)
    );

    mtfs_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_in    (s_tdata[PIX_W-1:0]),
        .motion_flag (s_tuser[0]),
        .reload      (s_tuser[1]),
        .cfg         (cfg),
        .last_idx    (last_idx),
        .fifo_count  (fifo_count),
        .push        (push),
        .push_beat   (push_beat)
    );

    mtfs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .count     (fifo_count)
    );

    assign m_tdata = out_beat.pixel_out;
    assign m_tlast = out_beat.frame_end;

endmodule

`default_nettype wire

// ===== tb/masked_temporal_frame_smoother_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_temporal_frame_smoother: a directed table, then
// randomized phases of settings and pixel streams, scored against a per-pixel
// smoothing predictor or typed table values. Depends on mtfs_pkg and the block's RTL.

module masked_temporal_frame_smoother_test;
    import mtfs_pkg::*;

    localparam int STORE_DEPTH   = MAX_PIXELS_DEF;
    localparam int PIPE_LATENCY  = 3;
    localparam int RANDOM_PIXELS = 1850;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

    // One step of the directed plan: a pixel beat or a register write
    typedef struct {
        row_kind_t             kind;
        logic [REG_IDX_W-1:0]  idx;
        logic [31:0]           value;
        logic [PIX_W-1:0]      pix;
        logic                  motion;
        logic                  reload;
        logic                  typed;
        logic [PIX_W-1:0]      exp_pix;
        logic                  exp_last;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [15:0] pixel_in
    logic [1:0]            s_tuser  = '0;   // [0] motion_flag, [1] reload
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [15:0] pixel_out
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: smoothed frame, written marks, position, register mirror
    bit   [PIX_W-1:0]   smooth_store [STORE_DEPTH];
    bit                 stored       [STORE_DEPTH];
    int unsigned        pix_pos      = 0;
    logic [GAIN_W-1:0]  gain_reg     = GAIN_RESET;
    logic               mask_reg     = 1'b0;
    logic [FRAME_W-1:0] frame_reg    = FRAME_RESET;

    out_beat_t pending_q [$];
    out_beat_t want;
    int error_count    = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int write_count    = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    plan_row_t plan [$] = '{
        // first pixels reload the store, extremes of the pixel range
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h8000, 1'b0, 1'b1, 1'b1, 16'h8000, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0001, 1'b1, 1'b1, 1'b1, 16'h0001, 1'b0},
        // frame shrunk below the current position: next pixel ends the frame
        '{ROW_WRITE, REG_FRAME_PIXELS, 32'd4, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h1234, 1'b0, 1'b1, 1'b1, 16'h1234, 1'b1},
        // default gain: full swing up, down, equal, and a step that truncates away
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h8000, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        // gain above one saturates to one
        '{ROW_WRITE, REG_GAIN, 32'h0001_FFFF, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hABCD, 1'b0, 1'b0, 1'b1, 16'hABCD, 1'b0},
        '{ROW_WRITE, REG_GAIN, 32'd0, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        // masking: hold without motion, update with motion, reload wins over mask
        '{ROW_WRITE, REG_MASK_ENABLE, 32'd1, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_WRITE, REG_GAIN, 32'd65536, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h5555, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hAAAA, 1'b1, 1'b0, 1'b1, 16'hAAAA, 1'b1},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h7777, 1'b0, 1'b1, 1'b1, 16'h7777, 1'b0},
        '{ROW_WRITE, REG_MASK_ENABLE, 32'd0, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_WRITE, REG_GAIN, 32'd32768, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        // write to an unmapped register is dropped
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        // frame size zero acts as one pixel per frame
        '{ROW_WRITE, REG_FRAME_PIXELS, 32'd0, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0F0F, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hF0F0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h1111, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        // oversized frame saturates to the store size
        '{ROW_WRITE, REG_FRAME_PIXELS, 32'h0007_FFFF, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h4321, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        // two-pixel frames back to back: store read right after its own write
        '{ROW_WRITE, REG_FRAME_PIXELS, 32'd2, 16'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h8001, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h7FFE, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0},
        '{ROW_BEAT,  REG_GAIN, 32'd0, 16'h0001, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0}
    };

    masked_temporal_frame_smoother u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Smoothed value and frame end for one pixel; advances the predictor state
    function automatic out_beat_t predict_smoothed(logic [PIX_W-1:0] pix, logic motion,
                                                   logic reload);
        int unsigned     size;
        int unsigned     g;
        logic [PIX_W-1:0] prev;
        logic [PIX_W-1:0] res;
        longint unsigned delta;
        out_beat_t       beat;
        if (frame_reg == 0)
            size = 1;
        else if (frame_reg > STORE_DEPTH)
            size = STORE_DEPTH;
        else
            size = frame_reg;
        g = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
        prev = smooth_store[pix_pos];
        if (reload) begin
            res = pix;
        end else if (mask_reg && !motion) begin
            res = prev;
        end else if (pix >= prev) begin
            delta = pix - prev;
            res = prev + PIX_W'((delta * g) >> 16);
        end else begin
            delta = prev - pix;
            res = prev - PIX_W'((delta * g) >> 16);
        end
        smooth_store[pix_pos] = res;
        stored[pix_pos] = 1'b1;
        beat.pixel_out = res;
        beat.frame_end = (pix_pos >= size - 1);
        pix_pos = beat.frame_end ? 0 : pix_pos + 1;
        return beat;
    endfunction

    // Queue the expectation, then offer the beat until it is taken
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic motion, logic reload,
                              logic typed, out_beat_t typed_beat);
        out_beat_t predicted;
        // never read a store entry that was not written
        if (!stored[pix_pos])
            reload = 1'b1;
        predicted = predict_smoothed(pix, motion, reload);
        pending_q.push_back(typed ? typed_beat : predicted);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= {reload, motion};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Drain all results and let the pipeline empty before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    // Write a register and, if it is mapped, mirror it and read it back
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        write_count++;
        case (idx)
            REG_GAIN: begin
                gain_reg = value[GAIN_W-1:0];
                readback = 32'(gain_reg);
            end
            REG_MASK_ENABLE: begin
                mask_reg = value[0];
                readback = 32'(mask_reg);
            end
            REG_FRAME_PIXELS: begin
                frame_reg = value[FRAME_W-1:0];
                readback = 32'(frame_reg);
            end
            default: return;
        endcase
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== readback)
            report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata,
                                      readback));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Result scoreboard and random output back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result %h last %b with nothing pending",
                                          m_tdata, m_tlast));
            end else begin
                want = pending_q.pop_front();
                checked_count++;
                if (m_tdata !== want.pixel_out)
                    report_mismatch($sformatf("result %0d pixel %h, want %h",
                                              checked_count, m_tdata, want.pixel_out));
                if (m_tlast !== want.frame_end)
                    report_mismatch($sformatf("result %0d frame end %b, want %b",
                                              checked_count, m_tlast, want.frame_end));
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Run-time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_q.size());
            $display("masked_temporal_frame_smoother_test: FAIL");
            $finish;
        end
    end

    initial begin
        out_beat_t        typed_beat;
        int               random_sent;
        int               burst;
        int unsigned      pick;
        logic [31:0]      gain_val;
        logic [31:0]      frame_val;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] prev_val;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        src_idle_pct   = 26;
        sink_stall_pct = 58;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_register(plan[i].idx, plan[i].value);
            end else begin
                typed_beat.pixel_out = plan[i].exp_pix;
                typed_beat.frame_end = plan[i].exp_last;
                send_pixel(plan[i].pix, plan[i].motion, plan[i].reload, plan[i].typed,
                           typed_beat);
            end
        end
        settle();

        // Random phases: new settings, then a burst of pixels
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            case (random_sent * 3 / RANDOM_PIXELS)
                0: begin src_idle_pct = 26; sink_stall_pct = 58; end
                1: begin src_idle_pct = 58; sink_stall_pct = 26; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            if ($urandom_range(3) == 0) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end

            pick = $urandom_range(9);
            case (pick)
                0: gain_val = 32'd0;
                1: gain_val = 32'd65536;
                2: gain_val = $urandom_range(131071, 65537);
                default: gain_val = $urandom_range(65536, 0);
            endcase
            write_register(REG_GAIN, gain_val);
            write_register(REG_MASK_ENABLE, 32'($urandom_range(1)));

            pick = $urandom_range(19);
            case (pick)
                0: frame_val = 32'd0;
                1: frame_val = $urandom_range(524287, 262145);
                2: frame_val = 32'd262144;
                3: frame_val = $urandom_range(3000, 200);
                4, 5, 6, 7: frame_val = $urandom_range(2, 1);
                default: frame_val = $urandom_range(40, 3);
            endcase
            write_register(REG_FRAME_PIXELS, frame_val);

            burst = $urandom_range(140, 40);
            repeat (burst) begin
                prev_val = smooth_store[pix_pos];
                pick = $urandom_range(7);
                case (pick)
                    0: pix = 16'h0000;
                    1: pix = 16'hFFFF;
                    2: pix = prev_val + PIX_W'($urandom_range(8)) - 16'd4;
                    default: pix = PIX_W'($urandom);
                endcase
                send_pixel(pix, 1'($urandom_range(1)), ($urandom_range(9) == 0), 1'b0, '0);
            end
            random_sent += burst;
            settle();
        end

        if (pending_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

        $display("covered %0d pixels in %0d register writes, %0d results compared",
                 sent_count, write_count, checked_count);
        $display("gain from zero past one, masking on and off, frames of 1 to 262144 pixels");
        if (error_count == 0)
            $display("masked_temporal_frame_smoother_test: PASS");
        else
            $display("masked_temporal_frame_smoother_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mtfs_pkg.sv
rtl/mtfs_cfg.sv
rtl/mtfs_datapath.sv
rtl/mtfs_out_fifo.sv
rtl/masked_temporal_frame_smoother.sv
tb/masked_temporal_frame_smoother_test.sv
